>>> hw/rtl/tsc_pkg.sv
package tsc_pkg;

   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic REG_GRAY_THRESHOLD    = 1'b0;
   localparam logic REG_MAX_BRIGHT_PIXELS = 1'b1;

   localparam logic [10:0] COUNT_MAX = 11'd2047;
   localparam logic [9:0]  COORD_MAX = 10'd1023;

   localparam logic [7:0] GRAY_THRESHOLD_RESET    = 8'd80;
   localparam logic [9:0] MAX_BRIGHT_PIXELS_RESET = 10'd60;

   typedef struct packed {
      logic [7:0] gray_threshold;
      logic [9:0] max_bright_pixels;
   } cfg_type;

   typedef struct packed {
      logic ready;
      logic take;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [9:0]  spot_x;
      logic [9:0]  spot_y;
      logic [10:0] bright_count;
      logic        found;
      logic        overloaded;
   } result_type;

endpackage

>>> hw/rtl/tsc_req_if.sv
interface tsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       row_end;
   logic       frame_end;

   modport source (output valid, output pixel, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input pixel, input row_end, input frame_end,
                   output ready);
endinterface

>>> hw/rtl/tsc_rsp_if.sv
interface tsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  spot_x;
   logic [9:0]  spot_y;
   logic [10:0] bright_count;
   logic        found;
   logic        overloaded;

   modport source (output valid, output spot_x, output spot_y, output bright_count,
                   output found, output overloaded, input ready);
   modport sink   (input valid, input spot_x, input spot_y, input bright_count,
                   input found, input overloaded, output ready);
endinterface

>>> hw/rtl/tsc_csr.sv
module tsc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tsc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output tsc_pkg::cfg_type                  cfg
);

   logic [7:0] threshold_ff, threshold_in;
   logic [9:0] max_bright_ff, max_bright_in;
   logic       write;
   logic       index;

   assign pready = 1'b1;
   assign write  = psel & penable & pwrite;
   assign index  = paddr[2];

   always_comb begin
      threshold_in  = threshold_ff;
      max_bright_in = max_bright_ff;
      if (write) begin
         unique case (index)
            tsc_pkg::REG_GRAY_THRESHOLD:    threshold_in  = pwdata[7:0];
            tsc_pkg::REG_MAX_BRIGHT_PIXELS: max_bright_in = pwdata[9:0];
            default:                        threshold_in  = threshold_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         tsc_pkg::REG_GRAY_THRESHOLD:    prdata = {24'd0, threshold_ff};
         tsc_pkg::REG_MAX_BRIGHT_PIXELS: prdata = {22'd0, max_bright_ff};
         default:                        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= tsc_pkg::GRAY_THRESHOLD_RESET;
         max_bright_ff <= tsc_pkg::MAX_BRIGHT_PIXELS_RESET;
      end else begin
         threshold_ff  <= threshold_in;
         max_bright_ff <= max_bright_in;
      end
   end

   assign cfg.gray_threshold    = threshold_ff;
   assign cfg.max_bright_pixels = max_bright_ff;

endmodule

>>> hw/rtl/tsc_ctrl.sv
module tsc_ctrl #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_frame_end,
   input  tsc_pkg::status_type  status,
   output tsc_pkg::cmd_type     cmd
);

   localparam int unsigned CW     = $clog2(MAX_COLUMNS);
   localparam int unsigned RW     = $clog2(MAX_ROWS);
   localparam int unsigned QW     = (CW > RW) ? CW : RW;
   localparam int unsigned STEP_W = $clog2(QW + 1);

   localparam logic [1:0] S_ACCUM  = 2'd0;
   localparam logic [1:0] S_DIVIDE = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.ready    = 1'b0;
      cmd.take     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         S_ACCUM: begin
            cmd.ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && req_frame_end) begin
               state_in = S_DIVIDE;
               step_in  = '0;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(QW - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_ACCUM;
            end
         end
         default: state_in = S_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> hw/rtl/tsc_datapath.sv
module tsc_datapath #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsc_pkg::cmd_type     cmd,
   output tsc_pkg::status_type  status,
   input  tsc_pkg::cfg_type     cfg,
   input  logic [7:0]           pixel,
   input  logic                 row_end,
   input  logic                 frame_end,
   output tsc_pkg::result_type  result,
   output logic                 result_valid,
   input  logic                 result_ready
);

   localparam int unsigned CW = $clog2(MAX_COLUMNS);
   localparam int unsigned RW = $clog2(MAX_ROWS);
   localparam int unsigned QW = (CW > RW) ? CW : RW;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [19:0]   wsum_ff, wsum_in;
   logic [31:0]   csum_ff, csum_in;
   logic [31:0]   rsum_ff, rsum_in;
   logic [10:0]   count_ff, count_in;
   logic          stopped_ff, stopped_in;

   logic          bright;
   logic          line_end;
   logic [CW+7:0] col_prod;
   logic [RW+7:0] row_prod;

   logic [19:0]   den_ff;
   logic [19:0]   rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [QW-1:0] quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [10:0]   count_cap_ff;
   logic          over_cap_ff;

   logic [20:0]   den_ext;
   logic [20:0]   trial_x, trial_y, diff_x, diff_y;
   logic          ge_x, ge_y;
   logic [QW:0]   shift_x, shift_y;
   logic [31:0]   csum_hi, rsum_hi;
   logic [31:0]   qx_ext, qy_ext;
   logic [9:0]    sat_x, sat_y;
   logic          found;

   tsc_pkg::result_type out_ff;
   logic                out_valid_ff, out_valid_in;

   assign bright   = !stopped_ff && (pixel > cfg.gray_threshold)
                     && (count_ff < tsc_pkg::COUNT_MAX);
   assign line_end = row_end | frame_end;
   assign col_prod = {{CW{1'b0}}, pixel} * {8'd0, col_ff};
   assign row_prod = {{RW{1'b0}}, pixel} * {8'd0, row_ff};

   always_comb begin
      wsum_in  = wsum_ff;
      csum_in  = csum_ff;
      rsum_in  = rsum_ff;
      count_in = count_ff;
      if (bright) begin
         wsum_in  = wsum_ff + {12'd0, pixel};
         csum_in  = csum_ff + 32'(col_prod);
         rsum_in  = rsum_ff + 32'(row_prod);
         count_in = count_ff + 11'd1;
      end
      stopped_in = stopped_ff | (line_end && (count_in > {1'b0, cfg.max_bright_pixels}));
      col_in = col_ff;
      row_in = row_ff;
      if (line_end) begin
         col_in = '0;
         if (row_ff < RW'(MAX_ROWS - 1)) begin
            row_in = row_ff + 1'b1;
         end
      end else if (col_ff < CW'(MAX_COLUMNS - 1)) begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         wsum_ff    <= '0;
         csum_ff    <= '0;
         rsum_ff    <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (cmd.take) begin
         if (frame_end) begin
            col_ff     <= '0;
            row_ff     <= '0;
            wsum_ff    <= '0;
            csum_ff    <= '0;
            rsum_ff    <= '0;
            count_ff   <= '0;
            stopped_ff <= 1'b0;
         end else begin
            col_ff     <= col_in;
            row_ff     <= row_in;
            wsum_ff    <= wsum_in;
            csum_ff    <= csum_in;
            rsum_ff    <= rsum_in;
            count_ff   <= count_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   // restoring division, one quotient bit per lane each step
   assign den_ext = {1'b0, den_ff};
   assign trial_x = {rem_x_ff, quo_x_ff[QW-1]};
   assign trial_y = {rem_y_ff, quo_y_ff[QW-1]};
   assign diff_x  = trial_x - den_ext;
   assign diff_y  = trial_y - den_ext;
   assign ge_x    = trial_x >= den_ext;
   assign ge_y    = trial_y >= den_ext;
   assign shift_x = {quo_x_ff, ge_x};
   assign shift_y = {quo_y_ff, ge_y};
   assign rem_x_in = ge_x ? diff_x[19:0] : trial_x[19:0];
   assign rem_y_in = ge_y ? diff_y[19:0] : trial_y[19:0];
   assign quo_x_in = shift_x[QW-1:0];
   assign quo_y_in = shift_y[QW-1:0];

   assign csum_hi = csum_in >> QW;
   assign rsum_hi = rsum_in >> QW;

   always_ff @(posedge clock) begin
      if (cmd.take && frame_end) begin
         den_ff       <= wsum_in;
         rem_x_ff     <= csum_hi[19:0];
         rem_y_ff     <= rsum_hi[19:0];
         quo_x_ff     <= csum_in[QW-1:0];
         quo_y_ff     <= rsum_in[QW-1:0];
         count_cap_ff <= count_in;
         over_cap_ff  <= stopped_in;
      end else if (cmd.div_step) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         quo_x_ff <= quo_x_in;
         quo_y_ff <= quo_y_in;
      end
   end

   assign found  = den_ff != 20'd0;
   assign qx_ext = 32'(quo_x_ff);
   assign qy_ext = 32'(quo_y_ff);
   assign sat_x  = (qx_ext > 32'(tsc_pkg::COORD_MAX)) ? tsc_pkg::COORD_MAX : qx_ext[9:0];
   assign sat_y  = (qy_ext > 32'(tsc_pkg::COORD_MAX)) ? tsc_pkg::COORD_MAX : qy_ext[9:0];

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff.spot_x       <= found ? sat_x : 10'd0;
         out_ff.spot_y       <= found ? sat_y : 10'd0;
         out_ff.bright_count <= count_cap_ff;
         out_ff.found        <= found;
         out_ff.overloaded   <= over_cap_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (result_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.out_free = !out_valid_ff | result_ready;
   assign result          = out_ff;
   assign result_valid    = out_valid_ff;

endmodule

>>> hw/rtl/thresholded_spot_centroid_core.sv
// Spot centroid of thresholded gray pixels.
// req carries one pixel per transfer in raster order, with row_end on the
// last pixel of each row and frame_end on the last pixel of the frame.
// Pixels above gray_threshold add to the weight and moment sums; a row-end
// bright count above max_bright_pixels freezes the sums for the frame.
// rsp carries one result per frame: weighted mean column and row, bright
// count, found and overloaded.
// Throughput: one pixel per cycle within a frame. After the frame-end
// transfer the block runs a restoring divider for Q quotient bits (one
// bit per cycle, Q = clog2 of the larger of MAX_COLUMNS and MAX_ROWS),
// then loads the output register once it is free, with req held not
// ready until that load; rsp valid is registered from the load.
// The output register holds the result while rsp is stalled; the next frame
// streams in meanwhile, and only its own result load waits for the register.
// Reset: synchronous; clears frame state, empties the output register and
// sets gray_threshold to 80 and max_bright_pixels to 60.
// CSR: gray_threshold at 0x0, max_bright_pixels at 0x4; to be written while idle (the block does not enforce this).
module thresholded_spot_centroid_core #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   tsc_req_if.sink                        req,
   tsc_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tsc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   tsc_pkg::cfg_type    cfg;
   tsc_pkg::cmd_type    cmd;
   tsc_pkg::status_type status;
   tsc_pkg::result_type result;

   tsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tsc_ctrl #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_frame_end (req.frame_end),
      .status        (status),
      .cmd           (cmd)
   );

   tsc_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg),
      .pixel        (req.pixel),
      .row_end      (req.row_end),
      .frame_end    (req.frame_end),
      .result       (result),
      .result_valid (rsp.valid),
      .result_ready (rsp.ready)
   );

   assign req.ready        = cmd.ready;
   assign rsp.spot_x       = result.spot_x;
   assign rsp.spot_y       = result.spot_y;
   assign rsp.bright_count = result.bright_count;
   assign rsp.found        = result.found;
   assign rsp.overloaded   = result.overloaded;

endmodule
